/* hw/rtl/ship_stream_drrip_replacement_assert.svh */
// Assertion macros for the checker file of the replacement engine.
// Depends on nothing; each macro expects signals clk and rst in scope.
`ifndef SHIP_STREAM_DRRIP_REPLACEMENT_ASSERT_SVH
`define SHIP_STREAM_DRRIP_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDRRIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDRRIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sdrrip_pkg.sv */
// Shared types and constants of the replacement engine.
// Depends on nothing; used by the front, back and top-level modules.
package sdrrip_pkg;

  localparam int ADDR_W = 58;
  localparam int CNT_W  = 8;
  localparam int MODE_W = 2;

  localparam logic [1:0] RRPV_MAX    = 2'd3;
  localparam logic [1:0] RRPV_NEAR   = 2'd2;
  localparam logic [1:0] RRPV_HOT    = 2'd0;
  localparam logic [1:0] REUSE_MAX   = 2'd3;
  localparam logic [1:0] REUSE_RESET = 2'd1;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STREAM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECENT = 2'd2;

  localparam logic       CMD_VICTIM = 1'b0;
  localparam logic       CMD_UPDATE = 1'b1;
  localparam logic [1:0] ACC_LOAD   = 2'd0;

  localparam logic [7:0]  THR_RESET  = 8'd12;
  localparam logic [10:0] LEAD_RESET = 11'd32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LEADERS   = 1'b1;

  // Classification of one queued beat.
  typedef struct packed {
    logic       cmd;
    logic       hit;
    logic       load;
    logic       is_s;
    logic       is_b;
    logic [2:0] rbyp;
    logic [4:0] rbr;
  } item_cls_t;

  // Per-set stream detector row.
  typedef struct packed {
    logic [ADDR_W-1:0] last_addr;
    logic [CNT_W-1:0]  count;
    logic [MODE_W-1:0] mode;
  } stream_row_t;

endpackage

/* hw/rtl/ship_stream_drrip_replacement.sv */
// Top level of the stream-aware DRRIP replacement engine with its register port.
// Depends on sdrrip_pkg, sdrrip_front, sdrrip_back and sdrrip_ram.
//
// Usage: the input channel (in_valid/in_ready) carries one beat per cache
// access: a victim command asks for the way to evict in a set, an update
// command reports a hit or fill. Every beat produces exactly one result beat
// on the output channel (out_valid/out_ready), in order.
// The read-modify-write of the set row bounds throughput: one state reads the
// row, stream row and reuse counter, the next writes them back and loads the
// output register. The back end takes a new beat from the queue only after it
// has written back the last one.
// A two-entry queue sits between the front end and the back end. While a
// result waits, the back end still reads the next beat, so up to three
// further beats are taken. When the receiver stalls, the result is held in
// the output register and the back end waits; the queue then fills and
// in_ready drops.
// After reset the engine runs a clearing pass over max(SETS, REUSE_ENTRIES)
// indices (8192 with the default sizes) that presets every line to distant
// re-reference, every reuse counter to one and every stream row to zero;
// in_ready stays low during the pass. Register writes are taken at any time.
// Registers: address 0 holds the stream threshold, address 4 the leader count.
module ship_stream_drrip_replacement #(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int REUSE_ENTRIES = 8192,
  parameter int SELECTOR_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [10:0] set_index,
  input  logic [3:0]  way,
  input  logic [57:0] block_address,
  input  logic [63:0] pc,
  input  logic [1:0]  access_type,
  input  logic        hit_flag,
  input  logic [2:0]  random_bypass,
  input  logic [4:0]  random_brrip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  victim_way,
  output logic [1:0]  inserted_rrpv,
  output logic        bypassed,
  output logic [1:0]  stream_mode_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sdrrip_pkg::*;

  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int SIG_W = $clog2(REUSE_ENTRIES);

  logic [7:0]  stream_threshold;
  logic [10:0] leader_sets;

  // Queue interface between the two halves.
  logic              q_valid;
  logic              q_ready;
  item_cls_t         q_cls;
  logic [SET_W-1:0]  q_set;
  logic [WAY_W-1:0]  q_way;
  logic [SIG_W-1:0]  q_sig;
  logic [ADDR_W-1:0] q_addr;
  logic              busy;

  // The register port never waits. Only paddr[2] selects a register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_threshold <= THR_RESET;
      leader_sets      <= LEAD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_THRESHOLD: stream_threshold <= pwdata[7:0];
        REG_LEADERS:   leader_sets      <= pwdata[10:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {24'd0, stream_threshold};
      REG_LEADERS:   prdata = {21'd0, leader_sets};
      default:       prdata = '0;
    endcase
  end

  sdrrip_front #(
    .SETS(SETS), .WAYS(WAYS), .REUSE_ENTRIES(REUSE_ENTRIES)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .set_index(set_index), .way(way),
    .block_address(block_address), .pc(pc), .access_type(access_type),
    .hit_flag(hit_flag), .random_bypass(random_bypass),
    .random_brrip(random_brrip), .leader_sets(leader_sets), .busy(busy),
    .q_valid(q_valid), .q_ready(q_ready), .q_cls(q_cls), .q_set(q_set),
    .q_way(q_way), .q_sig(q_sig), .q_addr(q_addr)
  );

  sdrrip_back #(
    .SETS(SETS), .WAYS(WAYS), .REUSE_ENTRIES(REUSE_ENTRIES),
    .SELECTOR_BITS(SELECTOR_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_cls(q_cls), .q_set(q_set),
    .q_way(q_way), .q_sig(q_sig), .q_addr(q_addr),
    .stream_threshold(stream_threshold), .busy(busy),
    .out_valid(out_valid), .out_ready(out_ready), .victim_way(victim_way),
    .inserted_rrpv(inserted_rrpv), .bypassed(bypassed),
    .stream_mode_out(stream_mode_out)
  );

endmodule

/* hw/rtl/sdrrip_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sdrrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/sdrrip_front.sv */
// Front end: takes input beats, reduces them to set, way, signature and leader
// flags, and holds them in a two-entry queue. Depends on sdrrip_pkg.
module sdrrip_front #(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int REUSE_ENTRIES = 8192
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [10:0]                       set_index,
  input  logic [3:0]                        way,
  input  logic [57:0]                       block_address,
  input  logic [63:0]                       pc,
  input  logic [1:0]                        access_type,
  input  logic                              hit_flag,
  input  logic [2:0]                        random_bypass,
  input  logic [4:0]                        random_brrip,
  input  logic [10:0]                       leader_sets,
  input  logic                              busy,
  output logic                              q_valid,
  input  logic                              q_ready,
  output sdrrip_pkg::item_cls_t             q_cls,
  output logic [$clog2(SETS)-1:0]           q_set,
  output logic [$clog2(WAYS)-1:0]           q_way,
  output logic [$clog2(REUSE_ENTRIES)-1:0]  q_sig,
  output logic [sdrrip_pkg::ADDR_W-1:0]     q_addr
);
  import sdrrip_pkg::*;

  localparam int SET_W  = $clog2(SETS);
  localparam int WAY_W  = $clog2(WAYS);
  localparam int SIG_W  = $clog2(REUSE_ENTRIES);
  localparam int LEAD_W = SET_W + 1;
  localparam int ENT_W  = $bits(item_cls_t) + SET_W + WAY_W + SIG_W + ADDR_W;

  logic [SET_W-1:0]  set_c;
  logic [WAY_W-1:0]  way_c;
  logic [SIG_W-1:0]  sig_c;
  logic [LEAD_W-1:0] lead_c;
  item_cls_t         cls_c;
  logic [ENT_W-1:0]  ent_c;

  logic [ENT_W-1:0] fifo [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  always_comb begin
    set_c  = SET_W'(32'(set_index) % SETS);
    way_c  = WAY_W'(32'(way) % WAYS);
    sig_c  = SIG_W'((pc ^ (pc >> 16)) % 64'(REUSE_ENTRIES));
    lead_c = (32'(leader_sets) > SETS) ? LEAD_W'(SETS) : LEAD_W'(leader_sets);
    cls_c.cmd  = command;
    cls_c.hit  = hit_flag;
    cls_c.load = (access_type == ACC_LOAD);
    cls_c.is_s = ({1'b0, set_c} < lead_c);
    cls_c.is_b = ({1'b0, set_c} >= (LEAD_W'(SETS) - lead_c));
    cls_c.rbyp = random_bypass;
    cls_c.rbr  = random_brrip;
    ent_c = {cls_c, set_c, way_c, sig_c, block_address};
  end

  assign in_ready = (count != 2'd2) && !busy;
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign {q_cls, q_set, q_way, q_sig, q_addr} = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= ent_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hw/rtl/sdrrip_back.sv */
// Back end: clearing pass, read-modify-write of the set row, stream row and
// reuse counter, selector training and the output register.
// Depends on sdrrip_pkg and sdrrip_ram.
module sdrrip_back #(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int REUSE_ENTRIES = 8192,
  parameter int SELECTOR_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  sdrrip_pkg::item_cls_t             q_cls,
  input  logic [$clog2(SETS)-1:0]           q_set,
  input  logic [$clog2(WAYS)-1:0]           q_way,
  input  logic [$clog2(REUSE_ENTRIES)-1:0]  q_sig,
  input  logic [sdrrip_pkg::ADDR_W-1:0]     q_addr,
  input  logic [7:0]                        stream_threshold,
  output logic                              busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0]                        victim_way,
  output logic [1:0]                        inserted_rrpv,
  output logic                              bypassed,
  output logic [1:0]                        stream_mode_out
);
  import sdrrip_pkg::*;

  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int SIG_W = $clog2(REUSE_ENTRIES);
  localparam int ROW_W = 2 * WAYS;
  localparam int SRW_W = $bits(stream_row_t);
  localparam int CLR_D = (SETS > REUSE_ENTRIES) ? SETS : REUSE_ENTRIES;
  localparam int CLR_W = $clog2(CLR_D);
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SEL_MAX >> 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]               state;
  logic [CLR_W-1:0]         clr_idx;
  logic [SELECTOR_BITS-1:0] sel;
  logic [SELECTOR_BITS-1:0] sel_next;
  logic [SELECTOR_BITS-1:0] sel_inc;

  item_cls_t         cur_cls;
  logic [SET_W-1:0]  cur_set;
  logic [WAY_W-1:0]  cur_way;
  logic [SIG_W-1:0]  cur_sig;
  logic [ADDR_W-1:0] cur_addr;

  logic [ROW_W-1:0] row_rd;
  logic [SRW_W-1:0] srow_raw;
  stream_row_t      srow;
  stream_row_t      srow_new;
  logic [1:0]       rc;

  logic             clearing;
  logic             rd_en;
  logic             exec;
  logic             rrpv_we;
  logic [SET_W-1:0] rrpv_waddr;
  logic [ROW_W-1:0] rrpv_wdata;
  logic             strm_we;
  logic [SET_W-1:0] strm_waddr;
  logic [SRW_W-1:0] strm_wdata;
  logic             reuse_we;
  logic [SIG_W-1:0] reuse_waddr;
  logic [1:0]       reuse_wdata;

  logic             hi_any;
  logic             lo_any;
  logic [1:0]       top;
  logic [1:0]       gap;
  logic [2:0]       sum;
  logic [ROW_W-1:0] aged;
  logic [WAY_W-1:0] vic;
  logic             vic_found;
  logic             unit_step;
  logic [1:0]       depth;
  logic             bypass;
  logic [1:0]       ins;
  logic [ROW_W-1:0] upd_row;

  assign clearing = (state == ST_CLEAR);
  assign busy     = clearing;
  assign q_ready  = (state == ST_ISSUE);
  assign rd_en    = q_valid && q_ready;
  assign exec     = (state == ST_EXEC) && (!out_valid || out_ready);
  assign srow     = stream_row_t'(srow_raw);

  sdrrip_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rrpv_ram (
    .clk(clk), .we(rrpv_we), .waddr(rrpv_waddr), .wdata(rrpv_wdata),
    .re(rd_en), .raddr(q_set), .rdata(row_rd)
  );

  sdrrip_ram #(.WIDTH(SRW_W), .DEPTH(SETS)) u_stream_ram (
    .clk(clk), .we(strm_we), .waddr(strm_waddr), .wdata(strm_wdata),
    .re(rd_en), .raddr(q_set), .rdata(srow_raw)
  );

  sdrrip_ram #(.WIDTH(2), .DEPTH(REUSE_ENTRIES)) u_reuse_ram (
    .clk(clk), .we(reuse_we), .waddr(reuse_waddr), .wdata(reuse_wdata),
    .re(rd_en), .raddr(q_sig), .rdata(rc)
  );

  // Victim aging: the largest value is found from the bit planes.
  always_comb begin
    hi_any = 1'b0;
    lo_any = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hi_any = hi_any | row_rd[2*w+1];
    end
    for (int w = 0; w < WAYS; w++) begin
      lo_any = lo_any | (row_rd[2*w] & (row_rd[2*w+1] | !hi_any));
    end
    top = {hi_any, lo_any};
    gap = RRPV_MAX - top;
    aged = '0;
    for (int w = 0; w < WAYS; w++) begin
      sum = {1'b0, row_rd[2*w +: 2]} + {1'b0, gap};
      aged[2*w +: 2] = (sum > 3'(RRPV_MAX)) ? RRPV_MAX : sum[1:0];
    end
    vic = '0;
    vic_found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!vic_found && (aged[2*w +: 2] == RRPV_MAX)) begin
        vic = WAY_W'(w);
        vic_found = 1'b1;
      end
    end
  end

  // Stream detector and insertion depth.
  always_comb begin
    unit_step = ({1'b0, cur_addr} == ({1'b0, srow.last_addr} + 59'd1)) ||
                ({1'b0, srow.last_addr} == ({1'b0, cur_addr} + 59'd1));
    srow_new.last_addr = cur_addr;
    if (unit_step) begin
      srow_new.count = (srow.count != CNT_MAX) ? srow.count + 8'd1 : srow.count;
    end else begin
      srow_new.count = (srow.count != '0) ? srow.count - 8'd1 : srow.count;
    end
    srow_new.mode = srow.mode;
    if (srow_new.count >= stream_threshold) begin
      srow_new.mode = MODE_STREAM;
    end else if (srow.mode == MODE_STREAM && srow_new.count < (stream_threshold >> 1)) begin
      srow_new.mode = MODE_RECENT;
    end else if (srow.mode == MODE_RECENT && srow_new.count < (stream_threshold >> 2)) begin
      srow_new.mode = MODE_NONE;
    end

    if (rc >= 2'd2) begin
      depth = RRPV_HOT;
    end else if (rc == 2'd1) begin
      depth = RRPV_NEAR;
    end else begin
      depth = RRPV_MAX;
    end
    if (cur_cls.is_s || (!cur_cls.is_b && sel >= SEL_HALF)) begin
      if (depth > RRPV_NEAR) begin
        depth = RRPV_NEAR;
      end
    end else if (cur_cls.is_b) begin
      if (cur_cls.rbr == '0) begin
        depth = RRPV_MAX;
      end else if (depth > RRPV_NEAR) begin
        depth = RRPV_NEAR;
      end
    end

    bypass = !cur_cls.hit && (srow_new.mode == MODE_STREAM) && (cur_cls.rbyp != '0);
    if (cur_cls.hit) begin
      ins = RRPV_HOT;
    end else if (bypass) begin
      ins = RRPV_MAX;
    end else begin
      ins = depth;
    end
    upd_row = row_rd;
    upd_row[2*cur_way +: 2] = ins;
  end

  // Selector training: increment for SRRIP leaders, then decrement for BRRIP.
  always_comb begin
    sel_inc  = (cur_cls.is_s && sel != SEL_MAX) ? sel + 1'b1 : sel;
    sel_next = (cur_cls.is_b && sel_inc != '0) ? sel_inc - 1'b1 : sel_inc;
  end

  // Write ports: the clearing pass, then the write-back of each beat.
  always_comb begin
    if (clearing) begin
      rrpv_we     = (32'(clr_idx) < SETS);
      rrpv_waddr  = clr_idx[SET_W-1:0];
      rrpv_wdata  = '1;
      strm_we     = (32'(clr_idx) < SETS);
      strm_waddr  = clr_idx[SET_W-1:0];
      strm_wdata  = '0;
      reuse_we    = (32'(clr_idx) < REUSE_ENTRIES);
      reuse_waddr = clr_idx[SIG_W-1:0];
      reuse_wdata = REUSE_RESET;
    end else begin
      rrpv_we     = exec;
      rrpv_waddr  = cur_set;
      rrpv_wdata  = (cur_cls.cmd == CMD_VICTIM) ? aged : upd_row;
      strm_we     = exec && (cur_cls.cmd == CMD_UPDATE);
      strm_waddr  = cur_set;
      strm_wdata  = srow_new;
      reuse_we    = exec && (cur_cls.cmd == CMD_UPDATE) && cur_cls.hit;
      reuse_waddr = cur_sig;
      reuse_wdata = (rc != REUSE_MAX) ? rc + 2'd1 : rc;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_cls  <= q_cls;
      cur_set  <= q_set;
      cur_way  <= q_way;
      cur_sig  <= q_sig;
      cur_addr <= q_addr;
    end
    if (exec) begin
      if (cur_cls.cmd == CMD_VICTIM) begin
        victim_way      <= 4'(vic);
        inserted_rrpv   <= RRPV_HOT;
        bypassed        <= 1'b0;
        stream_mode_out <= srow.mode;
      end else begin
        victim_way      <= '0;
        inserted_rrpv   <= ins;
        bypassed        <= bypass;
        stream_mode_out <= srow_new.mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      sel       <= SEL_HALF;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CLR_W'(CLR_D - 1)) begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (rd_en) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec) begin
            state <= ST_ISSUE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
      if (exec && cur_cls.cmd == CMD_UPDATE && cur_cls.hit && cur_cls.load) begin
        sel <= sel_next;
      end
      if (exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/sdrrip_checker.sv */
// Port-level checker of the replacement engine and its bind statement.
// Depends on ship_stream_drrip_replacement_assert.svh.
`include "ship_stream_drrip_replacement_assert.svh"

module sdrrip_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] victim_way,
  input logic [1:0] inserted_rrpv,
  input logic       bypassed,
  input logic [1:0] stream_mode_out
);

  // A stalled result stays offered; its victim way, inserted RRPV and stream mode stay stable.
  `SDRRIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SDRRIP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(victim_way) && $stable(inserted_rrpv) && $stable(stream_mode_out), "result changed while stalled")

  // The stream mode has three levels only.
  `SDRRIP_ASSERT_NOW(a_mode_legal, out_valid, stream_mode_out != 2'd3, "illegal stream mode")

  // A bypassed miss is inserted at distant re-reference and names no victim.
  `SDRRIP_ASSERT_NOW(a_bypass_rrpv, out_valid && bypassed, inserted_rrpv == 2'd3 && victim_way == 4'd0, "bypass with wrong insertion")

endmodule

bind ship_stream_drrip_replacement sdrrip_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .victim_way(victim_way), .inserted_rrpv(inserted_rrpv), .bypassed(bypassed),
  .stream_mode_out(stream_mode_out)
);

/* tb/sv/tb_ship_stream_drrip_replacement.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the stream-aware DRRIP replacement engine.
// Depends on sdrrip_pkg and ship_stream_drrip_replacement; it predicts every result beat itself.
module tb_ship_stream_drrip_replacement;
  import sdrrip_pkg::*;

  localparam int NSETS = 2048;
  localparam int NWAYS = 16;
  localparam int NREUSE = 8192;
  localparam int SELMAX = 1023;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [2:0] ADDR_THR = 3'd0;
  localparam logic [2:0] ADDR_LEAD = 3'd4;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic command, hit_flag, bypassed;
  logic [10:0] set_index;
  logic [3:0] way, victim_way;
  logic [57:0] block_address;
  logic [63:0] pc;
  logic [1:0] access_type, inserted_rrpv, stream_mode_out;
  logic [2:0] random_bypass;
  logic [4:0] random_brrip;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  ship_stream_drrip_replacement dut (.*);

  typedef struct packed {
    logic cmd;
    logic [10:0] set;
    logic [3:0] way;
    logic [57:0] addr;
    logic [63:0] pc;
    logic [1:0] atype;
    logic hit;
    logic [2:0] rbyp;
    logic [4:0] rbr;
  } access_t;

  typedef struct packed {
    logic [3:0] victim;
    logic [1:0] rrpv;
    logic byp;
    logic [1:0] mode;
  } decision_t;

  // Mirror of the engine's state.
  logic [1:0] rrpv_mem [NSETS*NWAYS];
  logic [1:0] reuse_mem [NREUSE];
  int unsigned selector;
  logic [57:0] last_addr [NSETS];
  logic [7:0] run_count [NSETS];
  logic [1:0] mode_mem [NSETS];
  logic [7:0] threshold;
  logic [10:0] leaders;

  decision_t pending_decisions[$];
  bit failed;
  int unsigned idle_cycles;
  bit idling_on;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic decision_t predict_decision(access_t a);
    decision_t d;
    int unsigned s, base, top, lead, sig;
    logic [1:0] depth;
    bit is_s, is_b;
    logic [57:0] prev;
    int unsigned cnt;
    logic [1:0] m;
    logic [63:0] fold;
    d = '0;
    s = a.set;
    base = s * NWAYS;
    if (a.cmd == CMD_VICTIM) begin
      // Age the row so the oldest line reaches distant, then take the first one.
      top = 0;
      for (int w = 0; w < NWAYS; w++) if (rrpv_mem[base+w] > top) top = rrpv_mem[base+w];
      for (int w = 0; w < NWAYS; w++) rrpv_mem[base+w] += 2'(3 - top);
      for (int w = NWAYS - 1; w >= 0; w--) if (rrpv_mem[base+w] == RRPV_MAX) d.victim = 4'(w);
      d.mode = mode_mem[s];
      return d;
    end
    // Stream detector, applied on every update. The step is compared one bit wider
    // so that the top address does not wrap onto zero.
    prev = last_addr[s];
    cnt = run_count[s];
    m = mode_mem[s];
    if ({1'b0, a.addr} == {1'b0, prev} + 59'd1 || {1'b0, prev} == {1'b0, a.addr} + 59'd1) begin
      if (cnt < 255) cnt++;
    end else if (cnt > 0) begin
      cnt--;
    end
    last_addr[s] = a.addr;
    if (cnt >= threshold) m = MODE_STREAM;
    else if (m == MODE_STREAM && cnt < (threshold >> 1)) m = MODE_RECENT;
    else if (m == MODE_RECENT && cnt < (threshold >> 2)) m = MODE_NONE;
    run_count[s] = 8'(cnt);
    mode_mem[s] = m;
    d.mode = m;

    fold = a.pc ^ (a.pc >> 16);
    sig = fold[12:0];
    lead = (leaders > NSETS) ? NSETS : leaders;
    is_s = s < lead;
    is_b = s >= NSETS - lead;
    if (a.hit) begin
      if (reuse_mem[sig] < REUSE_MAX) reuse_mem[sig]++;
      rrpv_mem[base+a.way] = RRPV_HOT;
      if (a.atype == ACC_LOAD) begin
        if (is_s && selector < SELMAX) selector++;
        if (is_b && selector > 0) selector--;
      end
      return d;
    end
    if (m == MODE_STREAM && a.rbyp != 0) begin
      rrpv_mem[base+a.way] = RRPV_MAX;
      d.rrpv = RRPV_MAX;
      d.byp = 1'b1;
      return d;
    end
    if (reuse_mem[sig] >= 2) depth = RRPV_HOT;
    else if (reuse_mem[sig] == 1) depth = RRPV_NEAR;
    else depth = RRPV_MAX;
    if (is_s || (!is_b && selector >= SELMAX / 2)) begin
      if (depth > RRPV_NEAR) depth = RRPV_NEAR;
    end else if (is_b) begin
      if (a.rbr == 0) depth = RRPV_MAX;
      else if (depth > RRPV_NEAR) depth = RRPV_NEAR;
    end
    rrpv_mem[base+a.way] = depth;
    d.rrpv = depth;
    return d;
  endfunction

  task automatic reset_mirror();
    foreach (rrpv_mem[i]) rrpv_mem[i] = RRPV_MAX;
    foreach (reuse_mem[i]) reuse_mem[i] = REUSE_RESET;
    foreach (last_addr[i]) begin
      last_addr[i] = '0;
      run_count[i] = '0;
      mode_mem[i] = MODE_NONE;
    end
    selector = SELMAX / 2;
    threshold = THR_RESET;
    leaders = LEAD_RESET;
  endtask

  // One APB write: setup phase, then access phase, then the bus goes quiet; pready is always high.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_THR) threshold = value[7:0];
    else leaders = value[10:0];
    @(posedge clk);
  endtask

  // Drives one beat and waits for its acceptance. The expectation is computed when the
  // beat is taken, so it always sees state updated by every earlier beat.
  task automatic send_beat(access_t a, bit check_fixed, decision_t fixed);
    decision_t d;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {command, set_index, way, block_address, pc, access_type, hit_flag, random_bypass,
     random_brrip} <= a;
    do @(posedge clk); while (!in_ready);
    d = predict_decision(a);
    if (check_fixed && d != fixed) begin
      $error("directed row: expected %h, predictor %h", fixed, d);
      failed = 1'b1;
    end
    pending_decisions.push_back(d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Output side: random stall bursts and a check of every beat against the oldest expectation.
  int unsigned stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_decisions.size() == 0) begin
          $error("result beat with no expectation waiting");
          failed <= 1'b1;
        end else begin
          decision_t e;
          e = pending_decisions.pop_front();
          if (victim_way !== e.victim) begin
            $error("victim_way expected %0d actual %0d", e.victim, victim_way);
            failed <= 1'b1;
          end
          if (inserted_rrpv !== e.rrpv) begin
            $error("inserted_rrpv expected %0d actual %0d", e.rrpv, inserted_rrpv);
            failed <= 1'b1;
          end
          if (bypassed !== e.byp) begin
            $error("bypassed expected %0d actual %0d", e.byp, bypassed);
            failed <= 1'b1;
          end
          if (stream_mode_out !== e.mode) begin
            $error("stream_mode_out expected %0d actual %0d", e.mode, stream_mode_out);
            failed <= 1'b1;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog over cycles with no accepted beat; the clearing pass after reset fits within it.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic access_t random_access(bit streaming, int unsigned set_sel,
                                            logic [57:0] addr);
    access_t a;
    a.cmd = ($urandom_range(0, 3) == 0) ? CMD_VICTIM : CMD_UPDATE;
    a.set = 11'(set_sel);
    a.way = 4'($urandom);
    a.addr = streaming ? addr : {26'($urandom), 32'($urandom)};
    // A small pool of PCs makes reuse counters climb and saturate.
    a.pc = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 15)) << 20
                                       : {32'($urandom), 32'($urandom)};
    a.atype = 2'($urandom);
    a.hit = $urandom_range(0, 2) == 0;
    a.rbyp = 3'($urandom);
    a.rbr = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
    return a;
  endfunction

  // Directed rows: expectations are typed in only where they are obvious.
  typedef struct {
    access_t a;
    bit fixed;
    decision_t d;
  } row_t;
  row_t rows[$];

  task automatic add_row(logic cmd, int unsigned s, int unsigned w, logic [57:0] addr,
                         logic [63:0] p, logic [1:0] t, logic h, logic [2:0] rb,
                         logic [4:0] rr, bit fixed, decision_t d);
    row_t r;
    r.a = '{cmd, 11'(s), 4'(w), addr, p, t, h, rb, rr};
    r.fixed = fixed;
    r.d = d;
    rows.push_back(r);
  endtask

  initial begin
    access_t a;
    logic [57:0] cursor [4];
    int unsigned hot_sets [4];
    int unsigned phase_items;
    failed = 1'b0;
    idling_on = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    {command, set_index, way, block_address, pc, access_type, hit_flag, random_bypass,
     random_brrip} = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_mirror();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // After reset every line is distant, so a victim in a fresh set is way 0.
    add_row(CMD_VICTIM, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{4'd0, 2'd0, 1'b0, MODE_NONE});
    add_row(CMD_VICTIM, 2047, 0, 0, 0, 0, 0, 0, 0, 1, '{4'd0, 2'd0, 1'b0, MODE_NONE});
    // A miss with a reset reuse counter inserts near in an SRRIP leader set.
    add_row(CMD_UPDATE, 0, 15, '1, '1, 2'd1, 0, 7, 31, 1, '{4'd0, 2'd2, 1'b0, MODE_NONE});
    add_row(CMD_UPDATE, 5, 3, 0, 0, 0, 1, 0, 0, 1, '{4'd0, 2'd0, 1'b0, MODE_NONE});
    add_row(CMD_VICTIM, 5, 0, 0, 0, 0, 0, 0, 0, 1, '{4'd0, 2'd0, 1'b0, MODE_NONE});
    // Load hits in a BRRIP leader; then a BRRIP miss with a zero draw goes distant.
    add_row(CMD_UPDATE, 2040, 1, 7, 64'h1234, ACC_LOAD, 1, 0, 0, 0, '0);
    add_row(CMD_UPDATE, 2040, 2, 9, 64'hFFFF_0000_0000_0000, 2'd2, 0, 3, 0, 0, '0);
    add_row(CMD_UPDATE, 2041, 4, 11, 64'h77, 2'd3, 0, 0, 5'd16, 0, '0);
    add_row(CMD_UPDATE, 1000, 9, 42, 64'h0F0F, 2'd3, 1, 0, 0, 0, '0);
    add_row(CMD_UPDATE, 1000, 9, 43, 64'h0F0F, ACC_LOAD, 0, 0, 0, 0, '0);
    // A run of unit steps in one set reaches streaming, and its last miss is bypassed.
    for (int i = 0; i < 13; i++)
      add_row(CMD_UPDATE, 77, i, 58'd100 + 58'(i), 64'(i), 2'd0, 0, 3'd4, 5'd1, 0, '0);
    add_row(CMD_UPDATE, 77, 14, 58'd112, 0, 0, 0, 0, 1, 0, '0);
    add_row(CMD_VICTIM, 77, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    foreach (rows[i]) send_beat(rows[i].a, rows[i].fixed, rows[i].d);
    drain();

    // Random phases under several register settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(ADDR_THR, 32'd0); write_reg(ADDR_LEAD, 32'd0); end
        1: begin write_reg(ADDR_THR, 32'd255); write_reg(ADDR_LEAD, 32'd1024); end
        2: begin write_reg(ADDR_THR, 32'd4); write_reg(ADDR_LEAD, 32'd2047); end
        3: begin write_reg(ADDR_THR, 32'd8); write_reg(ADDR_LEAD, 32'd1500); end
        4: begin write_reg(ADDR_THR, 32'd6); write_reg(ADDR_LEAD, 32'd700); end
        default: begin write_reg(ADDR_THR, 32'd12); write_reg(ADDR_LEAD, 32'd32); end
      endcase
      idling_on = (ph != 5);
      foreach (hot_sets[k]) begin
        hot_sets[k] = $urandom_range(0, 2047);
        cursor[k] = {26'($urandom), 32'($urandom)};
      end
      phase_items = (ph == 5) ? 100 : 150;
      for (int i = 0; i < phase_items; i++) begin
        int k;
        k = $urandom_range(0, 3);
        if ($urandom_range(0, 4) != 0) begin
          // Well-formed stream: unit steps, mostly upward, in a few hot sets.
          if ($urandom_range(0, 3) == 0) cursor[k] = cursor[k] - 58'd1;
          else cursor[k] = cursor[k] + 58'd1;
          a = random_access(1'b1, hot_sets[k], cursor[k]);
        end else begin
          a = random_access(1'b0, $urandom_range(0, 2047), '0);
        end
        send_beat(a, 1'b0, '0);
      end
      drain();
    end

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
